// ===== src/jtct_pkg.sv =====
// ----------------------------------------------------------------------------
// jtct_pkg
// Shared codes for the job table tracker: command codes, status codes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package jtct_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_CUR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_STATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_PID  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIX,
        S_HEAD_RD,
        S_HEAD_SET,
        S_ADD_RD,
        S_ADD_WR,
        S_DONE
    } t_fsm;

endpackage

// ===== src/jtct_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// jtct_cmp_unit
// Shared compare and increment unit: matches one slot word against the
// job number or pid key and forms the next job number.
// ----------------------------------------------------------------------------
module jtct_cmp_unit #(
    parameter int JOB_NUMBER_BITS = 8,
    parameter int PID_W           = 16
) (
    input  logic [JOB_NUMBER_BITS-1:0] i_slot_num,
    input  logic [PID_W-1:0]           i_slot_pid,
    input  logic [7:0]                 i_key_job,
    input  logic [PID_W-1:0]           i_key_pid,
    input  logic                       i_by_pid,
    output logic                       o_hit,
    output logic [JOB_NUMBER_BITS-1:0] o_next_num,
    output logic                       o_next_ovf
);

    localparam int CMP_W = (JOB_NUMBER_BITS > 8) ? JOB_NUMBER_BITS : 8;

    logic [CMP_W-1:0]           slot_num_ext;
    logic [CMP_W-1:0]           key_job_ext;
    logic [JOB_NUMBER_BITS:0]   sum;

    // The key is widened rather than cut so that a key beyond the number
    // range can never alias a stored number.
    assign slot_num_ext = CMP_W'(i_slot_num);
    assign key_job_ext  = CMP_W'(i_key_job);
    assign o_hit        = i_by_pid ? (i_slot_pid == i_key_pid)
                                   : (slot_num_ext == key_job_ext);

    assign sum        = {1'b0, i_slot_num} + {{JOB_NUMBER_BITS{1'b0}}, 1'b1};
    assign o_next_num = sum[JOB_NUMBER_BITS-1:0];
    assign o_next_ovf = sum[JOB_NUMBER_BITS];

endmodule

// ===== src/job_table_current_tracker_core.sv =====
// ----------------------------------------------------------------------------
// job_table_current_tracker_core
// Ordered job table with current and previous job markers, run by a small
// sequencer over one slot memory and one shared compare unit.
// ----------------------------------------------------------------------------
// Usage: a request (i_cmd, i_job, i_pid, i_new_state) is taken at a rising
// edge where start is high and busy is low. The block then raises busy and
// walks the slot memory one slot per cycle. When done it shows one result
// (o_status, o_job_number, o_current_job, o_previous_job, o_job_count) for
// exactly one cycle with o_valid high; the receiver cannot stall it, so the
// result must be captured in that cycle. busy falls in the cycle after the
// strobe, and a new request may be taken then.
// Add reads the last slot and then writes the new one; unused command
// codes go straight to the result. Lookup and remove time is set by the
// single read port of the slot memory: lookup reads one slot a cycle and
// remove then shifts the following slots down one a cycle through the
// same port.
// Reset (synchronous, active low) empties the table and clears both
// markers; the slot memory itself is not cleared, since slots at or above
// the job count are never read.
// ----------------------------------------------------------------------------
module job_table_current_tracker_core #(
    parameter int MAX_JOBS        = 16,
    parameter int JOB_NUMBER_BITS = 8,
    parameter int PID_BITS        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_job,
    input  logic [15:0] i_pid,
    input  logic [7:0]  i_new_state,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_job_number,
    output logic [7:0]  o_current_job,
    output logic [7:0]  o_previous_job,
    output logic [4:0]  o_job_count
);

    // Only 16 pid bits arrive at the port, so at most that many are kept.
    localparam int PID_W  = (PID_BITS < 16) ? PID_BITS : 16;
    localparam int JNB    = JOB_NUMBER_BITS;
    localparam int AW     = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int WORD_W = JNB + PID_W + 8;
    localparam int CMP_W  = (JNB > 8) ? JNB : 8;

    // Each slot word is {job number, pid, state}. Slots 0 .. count-1 are the
    // live jobs in ascending number order.
    logic [WORD_W-1:0] r_slot_mem [MAX_JOBS];
    logic [WORD_W-1:0] r_rd;

    jtct_pkg::t_fsm r_state, n_state;

    logic [jtct_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [7:0]                    r_job, n_job;
    logic [PID_W-1:0]              r_pid, n_pid;
    logic [7:0]                    r_nst, n_nst;
    logic [CNT_W-1:0]              r_idx, n_idx;
    logic [AW-1:0]                 r_cidx, n_cidx;
    logic                          r_chk, n_chk;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [JNB-1:0]                r_cur, n_cur;
    logic [JNB-1:0]                r_prev, n_prev;
    logic [jtct_pkg::STATUS_W-1:0] r_status, n_status;
    logic [JNB-1:0]                r_found, n_found;

    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [JNB-1:0]   rd_num;
    logic [PID_W-1:0] rd_pid;
    logic             hit;
    logic [JNB-1:0]   next_num;
    logic             next_ovf;
    logic             scan_end;
    logic             table_full;
    logic [JNB-1:0]   add_num;
    logic             add_ovf;
    logic             cur_is_job;

    assign rd_num = r_rd[WORD_W-1 -: JNB];
    assign rd_pid = r_rd[8 +: PID_W];

    jtct_cmp_unit #(
        .JOB_NUMBER_BITS (JNB),
        .PID_W           (PID_W)
    ) u_cmp (
        .i_slot_num (rd_num),
        .i_slot_pid (rd_pid),
        .i_key_job  (r_job),
        .i_key_pid  (r_pid),
        .i_by_pid   (r_cmd == jtct_pkg::CMD_FIND_PID),
        .o_hit      (hit),
        .o_next_num (next_num),
        .o_next_ovf (next_ovf)
    );

    // The walk has drained once no read is in flight and the index has run
    // past the last live slot.
    assign scan_end   = !r_chk && (r_idx >= r_count);
    assign table_full = (r_count >= CNT_W'(MAX_JOBS));
    assign add_num    = (r_count == '0) ? JNB'(1) : next_num;
    assign add_ovf    = (r_count != '0) && next_ovf;
    assign cur_is_job = (CMP_W'(r_cur) == CMP_W'(r_job));

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_slot_mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jtct_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_cmd)
                        jtct_pkg::CMD_ADD:       n_state = jtct_pkg::S_ADD_RD;
                        jtct_pkg::CMD_REMOVE,
                        jtct_pkg::CMD_SET_CUR,
                        jtct_pkg::CMD_SET_STATE,
                        jtct_pkg::CMD_FIND_PID:  n_state = jtct_pkg::S_SCAN;
                        default:                 n_state = jtct_pkg::S_DONE;
                    endcase
                end
            end
            jtct_pkg::S_SCAN: begin
                if (r_chk && hit) begin
                    n_state = (r_cmd == jtct_pkg::CMD_REMOVE) ? jtct_pkg::S_SHIFT
                                                              : jtct_pkg::S_DONE;
                end else if (scan_end) begin
                    n_state = jtct_pkg::S_DONE;
                end
            end
            jtct_pkg::S_SHIFT: begin
                if (scan_end) begin
                    n_state = jtct_pkg::S_FIX;
                end
            end
            jtct_pkg::S_FIX: begin
                if ((r_count != CNT_W'(1)) && cur_is_job && (r_prev == '0)) begin
                    n_state = jtct_pkg::S_HEAD_RD;
                end else begin
                    n_state = jtct_pkg::S_DONE;
                end
            end
            jtct_pkg::S_HEAD_RD:  n_state = jtct_pkg::S_HEAD_SET;
            jtct_pkg::S_HEAD_SET: n_state = jtct_pkg::S_DONE;
            jtct_pkg::S_ADD_RD: begin
                n_state = table_full ? jtct_pkg::S_DONE : jtct_pkg::S_ADD_WR;
            end
            jtct_pkg::S_ADD_WR:   n_state = jtct_pkg::S_DONE;
            jtct_pkg::S_DONE:     n_state = jtct_pkg::S_IDLE;
            default:              n_state = jtct_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cmd    = r_cmd;
        n_job    = r_job;
        n_pid    = r_pid;
        n_nst    = r_nst;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_chk    = r_chk;
        n_count  = r_count;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_status = r_status;
        n_found  = r_found;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_cidx;
        wr_data  = r_rd;

        unique case (r_state)
            jtct_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_job    = i_job;
                    n_pid    = i_pid[PID_W-1:0];
                    n_nst    = i_new_state;
                    n_idx    = '0;
                    n_chk    = 1'b0;
                    n_status = jtct_pkg::ST_OK;
                    n_found  = '0;
                end
            end
            jtct_pkg::S_SCAN: begin
                // Issue the next slot read while checking the one before it.
                if (r_idx < r_count) begin
                    n_chk  = 1'b1;
                    n_cidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk && hit) begin
                    unique case (r_cmd)
                        jtct_pkg::CMD_REMOVE: begin
                            n_idx = CNT_W'(r_cidx) + CNT_W'(1);
                            n_chk = 1'b0;
                        end
                        jtct_pkg::CMD_SET_CUR: begin
                            n_prev = r_cur;
                            n_cur  = JNB'(r_job);
                        end
                        jtct_pkg::CMD_SET_STATE: begin
                            wr_en   = 1'b1;
                            wr_addr = r_cidx;
                            wr_data = {rd_num, rd_pid, r_nst};
                        end
                        default: begin
                            n_found = rd_num;
                        end
                    endcase
                end else if (scan_end) begin
                    n_status = jtct_pkg::ST_NOT_FOUND;
                end
            end
            jtct_pkg::S_SHIFT: begin
                // Slot i+1 is read and written back into slot i.
                if (r_idx < r_count) begin
                    n_chk  = 1'b1;
                    n_cidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cidx - AW'(1);
                    wr_data = r_rd;
                end
            end
            jtct_pkg::S_FIX: begin
                n_count = r_count - CNT_W'(1);
                // Removing the current job while others remain moves the
                // current marker to the previous one, or to the lowest job.
                if ((r_count != CNT_W'(1)) && cur_is_job) begin
                    if (r_prev != '0) begin
                        n_cur = r_prev;
                    end
                    n_prev = '0;
                end
            end
            jtct_pkg::S_HEAD_RD: begin
                rd_addr = '0;
            end
            jtct_pkg::S_HEAD_SET: begin
                n_cur = rd_num;
            end
            jtct_pkg::S_ADD_RD: begin
                rd_addr = AW'(r_count - CNT_W'(1));
                if (table_full) begin
                    n_status = jtct_pkg::ST_FULL;
                end
            end
            jtct_pkg::S_ADD_WR: begin
                if (add_ovf) begin
                    n_status = jtct_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[AW-1:0];
                    wr_data = {add_num, r_pid, r_nst};
                    if (r_count != '0) begin
                        n_prev = r_cur;
                    end
                    n_cur   = add_num;
                    n_count = r_count + CNT_W'(1);
                    n_found = add_num;
                end
            end
            jtct_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jtct_pkg::S_IDLE;
            r_chk   <= 1'b0;
            r_count <= '0;
            r_cur   <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
        end
    end

    // Request payload and working registers.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_job    <= n_job;
        r_pid    <= n_pid;
        r_nst    <= n_nst;
        r_idx    <= n_idx;
        r_cidx   <= n_cidx;
        r_status <= n_status;
        r_found  <= n_found;
    end

    // Outputs.
    always_comb begin
        busy           = (r_state != jtct_pkg::S_IDLE);
        o_valid        = (r_state == jtct_pkg::S_DONE);
        o_status       = r_status;
        o_job_number   = 8'(r_found);
        o_current_job  = 8'(r_cur);
        o_previous_job = 8'(r_prev);
        o_job_count    = 5'(r_count);
    end

    // The table never holds more jobs than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count beyond table size");

    // An accepted request keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A result strobe lasts exactly one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A successful add always reports a nonzero number that is now current.
    a_add_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cmd == jtct_pkg::CMD_ADD) && (o_status == jtct_pkg::ST_OK))
        |-> ((r_found != '0) && (r_found == r_cur)))
        else $error("add finished without a current job number");

endmodule

// ===== tb/job_table_current_tracker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// job_table_current_tracker_core_tb
// Self-checking bench for the job table tracker. A directed table of
// requests is run first, then a long random part. Every result is checked
// against a behavioral copy of the table kept inside the bench.
// ----------------------------------------------------------------------------
module job_table_current_tracker_core_tb;

    // Table size and field limits of the block as instantiated.
    localparam int          JOBS        = 16;
    localparam logic [7:0]  NUMBER_MAX  = 8'hFF;
    // Codes 5 to 7 are unused by the block; they must finish with status ok.
    localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    // Stimulus sizes and the watchdog.
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          CLIMB_AT     = 700;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 500000;

    // One request as it goes onto the ports.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  job;
        logic [15:0] pid;
        logic [7:0]  nst;
    } t_job_req;

    // One result as the block shows it for a single cycle.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] number;
        logic [7:0] cur;
        logic [7:0] prev;
        logic [4:0] count;
    } t_job_reply;

    // A row of the directed table. Rows that repeat or whose outcome is not
    // obvious leave the expectation to the table copy below.
    typedef struct {
        t_job_req   req;
        int         rep;
        bit         typed;
        t_job_reply reply;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd       = '0;
    logic [7:0]  i_job       = '0;
    logic [15:0] i_pid       = '0;
    logic [7:0]  i_new_state = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_job_number;
    logic [7:0]  o_current_job;
    logic [7:0]  o_previous_job;
    logic [4:0]  o_job_count;

    job_table_current_tracker_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_job          (i_job),
        .i_pid          (i_pid),
        .i_new_state    (i_new_state),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_job_number   (o_job_number),
        .o_current_job  (o_current_job),
        .o_previous_job (o_previous_job),
        .o_job_count    (o_job_count)
    );

    // 4 ns clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the job table. Entries stay packed in slots 0..count-1 in
    // ascending number order, exactly as the block keeps them.
    // ------------------------------------------------------------------------
    logic [7:0]  tbl_num   [JOBS];
    logic [15:0] tbl_pid   [JOBS];
    logic [7:0]  tbl_state [JOBS];
    int          tbl_count = 0;
    logic [7:0]  cur_mark  = '0;
    logic [7:0]  prev_mark = '0;

    // Results the block still owes, oldest first.
    t_job_reply  awaited_replies [$];
    t_job_reply  head_reply;

    int          mismatch_count = 0;
    int          item_count     = 0;
    int          cycle_count    = 0;
    int          idle_pct       = 0;
    int          adds_ok        = 0;
    int          full_hits      = 0;
    int          overflow_hits  = 0;
    int          not_found_hits = 0;
    int          spare_hits     = 0;

    // Slot of the job with this number, or -1. Number 0 is never stored, so
    // it can never match.
    function automatic int find_slot(input logic [7:0] num);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_num[i] == num) return i;
        end
        return -1;
    endfunction

    // Carries out one command on the bench copy and works out the result
    // the block must show for it.
    task automatic apply_job_command(input t_job_req r, output t_job_reply o);
        int         at;
        logic [8:0] next_num;
        o = '0;
        o.status = jtct_pkg::ST_OK;
        case (r.cmd)
            jtct_pkg::CMD_ADD: begin
                next_num = (tbl_count == 0) ? 9'd1 : {1'b0, tbl_num[tbl_count-1]} + 9'd1;
                if (tbl_count >= JOBS) begin
                    // Table full: nothing changes.
                    o.status = jtct_pkg::ST_FULL;
                    full_hits++;
                end else if (next_num > {1'b0, NUMBER_MAX}) begin
                    // The next number would not fit in the number field.
                    o.status = jtct_pkg::ST_FULL;
                    overflow_hits++;
                end else begin
                    tbl_num[tbl_count]   = next_num[7:0];
                    tbl_pid[tbl_count]   = r.pid;
                    tbl_state[tbl_count] = r.nst;
                    // On an empty table the previous marker is left alone.
                    if (tbl_count != 0) prev_mark = cur_mark;
                    cur_mark = next_num[7:0];
                    tbl_count++;
                    o.number = next_num[7:0];
                    adds_ok++;
                end
            end
            jtct_pkg::CMD_REMOVE: begin
                at = find_slot(r.job);
                if (at < 0) begin
                    o.status = jtct_pkg::ST_NOT_FOUND;
                    not_found_hits++;
                end else begin
                    for (int i = at; i + 1 < tbl_count; i++) begin
                        tbl_num[i]   = tbl_num[i+1];
                        tbl_pid[i]   = tbl_pid[i+1];
                        tbl_state[i] = tbl_state[i+1];
                    end
                    tbl_count--;
                    // Removing the current job hands the marker to the
                    // previous job, or failing that to the lowest number.
                    // An emptied table and stale markers are left as they are.
                    if (tbl_count != 0 && cur_mark == r.job) begin
                        cur_mark  = (prev_mark != 0) ? prev_mark : tbl_num[0];
                        prev_mark = '0;
                    end
                end
            end
            jtct_pkg::CMD_SET_CUR: begin
                if (find_slot(r.job) < 0) begin
                    o.status = jtct_pkg::ST_NOT_FOUND;
                    not_found_hits++;
                end else begin
                    prev_mark = cur_mark;
                    cur_mark  = r.job;
                end
            end
            jtct_pkg::CMD_SET_STATE: begin
                at = find_slot(r.job);
                if (at < 0) begin
                    o.status = jtct_pkg::ST_NOT_FOUND;
                    not_found_hits++;
                end else begin
                    tbl_state[at] = r.nst;
                end
            end
            jtct_pkg::CMD_FIND_PID: begin
                // The lowest slot holds the lowest number, so the first hit wins.
                o.status = jtct_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++) begin
                    if (o.status == jtct_pkg::ST_NOT_FOUND && tbl_pid[i] == r.pid) begin
                        o.status = jtct_pkg::ST_OK;
                        o.number = tbl_num[i];
                    end
                end
                if (o.status == jtct_pkg::ST_NOT_FOUND) not_found_hits++;
            end
            default: begin
                spare_hits++;
            end
        endcase
        o.cur   = cur_mark;
        o.prev  = prev_mark;
        o.count = tbl_count[4:0];
    endtask

    // ------------------------------------------------------------------------
    // Request driver. Fields and start change only at rising edges. A request
    // is taken at the edge where start is high and busy is low; start stays
    // high through busy, so a request may wait on any phase of the block's
    // work. Before each request the sender may go idle.
    // ------------------------------------------------------------------------
    task automatic issue(input t_job_req r, input bit typed, input t_job_reply typed_reply);
        t_job_reply pred;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_cmd       <= r.cmd;
        i_job       <= r.job;
        i_pid       <= r.pid;
        i_new_state <= r.nst;
        do @(posedge i_clk); while (busy);
        // The request was taken at this edge: update the copy and queue the
        // result. Rows with a typed result are still run through the copy so
        // that its state follows the block.
        apply_job_command(r, pred);
        awaited_replies.push_back(typed ? typed_reply : pred);
        item_count++;
    endtask

    task automatic issue_req(input logic [2:0] c, input logic [7:0] j,
                             input logic [15:0] p, input logic [7:0] s);
        issue('{cmd: c, job: j, pid: p, nst: s}, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Random field choices. Job numbers mostly name held jobs so that lookups
    // succeed; pids are drawn so that shared pids and misses both happen.
    // Full-range draws make every port bit take both values.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_job();
        if (tbl_count > 0 && $urandom_range(0, 99) < 70)
            return tbl_num[$urandom_range(0, tbl_count - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_pid();
        int roll;
        logic [15:0] pool [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
        roll = $urandom_range(0, 99);
        if (tbl_count > 0 && roll < 35) return tbl_pid[$urandom_range(0, tbl_count - 1)];
        if (roll < 60) return pool[$urandom_range(0, 3)];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] pick_state();
        return 8'($urandom_range(0, 255));
    endfunction

    // A burst of mixed commands with random content.
    task automatic mixed_burst(input int n);
        int roll;
        logic [2:0] c;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 28)      c = jtct_pkg::CMD_ADD;
            else if (roll < 48) c = jtct_pkg::CMD_REMOVE;
            else if (roll < 62) c = jtct_pkg::CMD_SET_CUR;
            else if (roll < 76) c = jtct_pkg::CMD_SET_STATE;
            else if (roll < 95) c = jtct_pkg::CMD_FIND_PID;
            else                c = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            issue_req(c, pick_job(), pick_pid(), pick_state());
        end
    endtask

    // Adds until the table is full or the numbers have run out, then one or
    // two more that must bounce.
    task automatic fill_table();
        while (tbl_count < JOBS &&
               (tbl_count == 0 || tbl_num[tbl_count-1] != NUMBER_MAX))
            issue_req(jtct_pkg::CMD_ADD, pick_job(), pick_pid(), pick_state());
        repeat ($urandom_range(1, 2))
            issue_req(jtct_pkg::CMD_ADD, pick_job(), pick_pid(), pick_state());
    endtask

    // Removes held jobs in random order until the table is empty.
    task automatic drain_table();
        while (tbl_count > 0)
            issue_req(jtct_pkg::CMD_REMOVE, tbl_num[$urandom_range(0, tbl_count - 1)],
                      pick_pid(), pick_state());
    endtask

    // Pushes job numbers up to the top of the number range by adding at the
    // tail and removing at the head, then tries adds that must overflow.
    // Lookups among the high numbers follow before the table is emptied.
    task automatic climb_numbers();
        while (tbl_count == 0 || tbl_num[tbl_count-1] != NUMBER_MAX) begin
            if (tbl_count >= 4)
                issue_req(jtct_pkg::CMD_REMOVE, tbl_num[0], pick_pid(), pick_state());
            else
                issue_req(jtct_pkg::CMD_ADD, pick_job(), pick_pid(), pick_state());
        end
        repeat (2) issue_req(jtct_pkg::CMD_ADD, pick_job(), pick_pid(), pick_state());
        mixed_burst(12);
        drain_table();
    endtask

    function automatic t_dir_row dir_row(input logic [2:0] c, input logic [7:0] j,
                                         input logic [15:0] p, input logic [7:0] s,
                                         input int n, input bit t, input logic [1:0] st,
                                         input logic [7:0] jn, input logic [7:0] cu,
                                         input logic [7:0] pv, input logic [4:0] ct);
        t_dir_row d;
        d.req   = '{cmd: c, job: j, pid: p, nst: s};
        d.rep   = n;
        d.typed = t;
        d.reply = '{status: st, number: jn, cur: cu, prev: pv, count: ct};
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor. The block holds each result for one cycle only, so it
    // is taken at the edge that ends the strobe cycle and compared field by
    // field with the oldest outstanding result.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t ns: result with no request outstanding, %s %0d",
                         $time, "expected none, actual status", o_status);
                mismatch_count++;
            end else begin
                head_reply = awaited_replies.pop_front();
                check_field("status",       head_reply.status, o_status);
                check_field("job_number",   head_reply.number, o_job_number);
                check_field("current_job",  head_reply.cur,    o_current_job);
                check_field("previous_job", head_reply.prev,   o_previous_job);
                check_field("job_count",    head_reply.count,  o_job_count);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_replies.size());
            $display("job_table_current_tracker_core_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [$];
    // Sender idle percentage per quarter of the random part: none, busy
    // sender, then the receiver phase (the receiver cannot stall, so this one
    // runs without idling), then the combined phase where only the sender's
    // share applies.
    int       phase_idle [4] = '{0, 51, 0, 36};
    int       random_done;
    bit       climbed;
    int       roll;

    initial begin
        // Synchronous reset, held low from the start and released once.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Comments give what each row exercises.
        // Empty table: every lookup misses, unused codes are harmless.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_FIND_PID, 8'd0, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd0, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_CUR, 8'hFF, 16'hFFFF, 8'hFF, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_STATE, 8'd1, 16'h0000, 8'hFF, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(CMD_SPARE_LO, 8'hFF, 16'hFFFF, 8'hFF, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(CMD_SPARE_HI, 8'h00, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd0, 8'd0, 5'd0));
        // Three adds; the first and third share a pid.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'hFFFF, 8'hFF, 1, 1,
            jtct_pkg::ST_OK, 8'd1, 8'd1, 8'd0, 5'd1));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd2, 8'd2, 8'd1, 5'd2));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'hFFFF, 8'h55, 1, 1,
            jtct_pkg::ST_OK, 8'd3, 8'd3, 8'd2, 5'd3));
        // Shared pid: the lowest number wins. Then a pid that is not held.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_FIND_PID, 8'd0, 16'hFFFF, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd1, 8'd3, 8'd2, 5'd3));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_FIND_PID, 8'd0, 16'h1234, 8'h00, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd3, 8'd2, 5'd3));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_CUR, 8'd1, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd1, 8'd3, 5'd3));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_STATE, 8'd2, 16'h0000, 8'hAA, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd1, 8'd3, 5'd3));
        // Job number zero never matches.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_STATE, 8'd0, 16'h0000, 8'h11, 1, 1,
            jtct_pkg::ST_NOT_FOUND, 8'd0, 8'd1, 8'd3, 5'd3));
        // Remove the current job while a previous one is marked.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd1, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd3, 8'd0, 5'd2));
        // Remove the current job with no previous: the lowest remaining wins.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd3, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd2, 8'd0, 5'd1));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_SET_CUR, 8'd2, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd2, 8'd2, 5'd1));
        // Emptying the table keeps both markers.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd2, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd2, 8'd2, 5'd0));
        // Add to an empty table: number 1, previous marker untouched.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'h00FF, 8'h01, 1, 1,
            jtct_pkg::ST_OK, 8'd1, 8'd1, 8'd2, 5'd1));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'hFF00, 8'h80, 1, 1,
            jtct_pkg::ST_OK, 8'd2, 8'd2, 8'd1, 5'd2));
        // Removing a job that is not current leaves a stale previous marker.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd1, 16'h0000, 8'h00, 1, 1,
            jtct_pkg::ST_OK, 8'd0, 8'd2, 8'd1, 5'd1));
        // Fill to the top, then one add too many.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'h8001, 8'h7F, 15, 0,
            jtct_pkg::ST_OK, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_ADD, 8'd0, 16'h8001, 8'h7F, 1, 1,
            jtct_pkg::ST_FULL, 8'd0, 8'd17, 8'd16, 5'd16));
        // Remove the tail job, then the head job with the longest shift.
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd17, 16'h0000, 8'h00, 1, 0,
            jtct_pkg::ST_OK, 8'd0, 8'd0, 8'd0, 5'd0));
        dir_rows.push_back(dir_row(jtct_pkg::CMD_REMOVE, 8'd2, 16'h0000, 8'h00, 1, 0,
            jtct_pkg::ST_OK, 8'd0, 8'd0, 8'd0, 5'd0));

        foreach (dir_rows[n]) begin
            repeat (dir_rows[n].rep)
                issue(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].reply);
        end

        // Random part: mixed bursts, fill and drain sequences, and one climb
        // of the job numbers up to overflow. The sender's idle rate moves
        // through the four phases as the part goes on.
        random_done = 0;
        climbed     = 1'b0;
        while (random_done < RANDOM_ITEMS) begin
            idle_pct = phase_idle[(random_done * 4) / RANDOM_ITEMS];
            roll = $urandom_range(0, 99);
            if (!climbed && random_done >= CLIMB_AT) begin
                climb_numbers();
                climbed = 1'b1;
            end else if (roll < 12) begin
                fill_table();
            end else if (roll < 24) begin
                drain_table();
            end else begin
                mixed_burst($urandom_range(8, 30));
            end
            random_done = item_count - 39;
        end

        // Stop requesting, wait for every outstanding result, then leave the
        // block time to show anything it should not.
        @(posedge i_clk);
        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d adds taken, %0d full and %0d overflow rejections,",
                 item_count, adds_ok, full_hits, overflow_hits);
        $display("%0d lookups that missed and %0d unused codes; %0d mismatches.",
                 not_found_hits, spare_hits, mismatch_count);
        if (mismatch_count == 0) begin
            $display("job_table_current_tracker_core_tb: clean");
        end else begin
            $display("job_table_current_tracker_core_tb: errors");
        end
        $finish;
    end

endmodule

// ===== job_table_current_tracker_core.f =====
src/jtct_pkg.sv
src/jtct_cmp_unit.sv
src/job_table_current_tracker_core.sv
tb/job_table_current_tracker_core_tb.sv
